@@ rtl/positional_list_engine_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent
`define PLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, field widths and request codes of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    // Field widths of the request and response beats
    localparam int REQ_W  = 3;
    localparam int POS_W  = 9;
    localparam int VAL_W  = 32;
    localparam int FPOS_W = 8;
    localparam int LEN_W  = 9;

    // Default sizing
    localparam int DEF_CAPACITY    = 256;
    localparam int DEF_VALUE_WIDTH = 32;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_SET    = 3'd2,
        OP_GET    = 3'd3,
        OP_REMOVE = 3'd4,
        OP_SEARCH = 3'd5
    } op_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } ple_req_t;

    typedef struct packed {
        logic              ok;
        logic [VAL_W-1:0]  read_value;
        logic [FPOS_W-1:0] found_position;
        logic [LEN_W-1:0]  length;
    } ple_rsp_t;

endpackage

@@ rtl/positional_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of up to CAPACITY values held in a rotating ring of cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request beat (req_type, position, value); the
//   m_ channel returns exactly one response beat per request with ok,
//   read_value, found_position and the list length after the request.
//   The elements sit in a ring of CAPACITY cells plus one seam cell. Every
//   request rotates the whole ring once, CAPACITY+1 shifts, and the seam
//   logic rewrites the word stream as it passes: inject for append, insert
//   and set, tap for get, skip the seam cell for remove, compare for search.
//   A new request is taken only in the idle state, after the current one
//   has run its full rotation of the ring and its finish state has loaded
//   the response register.
//   s_ready is high only in the idle state, even while a response
//   waits for m_ready. A finished request that finds the output register
//   still full holds the ring and waits until the response is taken.
//   Reset empties the list (length zero) and drops any pending response;
//   cell contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module positional_list_engine_unit import ple_pkg::*; #(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ple_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ple_rsp_t m_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          step_reg;
    logic [CW-1:0]          count_reg;
    op_t                    op_reg;
    logic                   act_reg;
    logic [PW-1:0]          pos_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [VALUE_WIDTH-1:0] carry_reg, carry_next;
    logic                   found_reg, found_next;
    logic [FPOS_W-1:0]      fpos_reg, fpos_next;
    logic [VAL_W-1:0]       rd_reg, rd_next;
    logic                   m_valid_reg;
    ple_rsp_t               m_data_reg;

    logic [VALUE_WIDTH-1:0] ring_q [CAPACITY];
    logic [VALUE_WIDTH-1:0] seam_q, seam_d, feed;
    logic                   shift_en, seam_en;
    logic [VALUE_WIDTH-1:0] head;

    logic                   accept, out_free, full, act_in;
    logic [PW-1:0]          pos_in, count_ext, step_ext;
    logic                   at_pos, past_pos, last_step;
    logic [CW-1:0]          count_new;
    logic                   ok_out;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign shift_en = (state_reg == ST_SWEEP);
    assign head     = ring_q[0];

    // Ring of element cells, shifting toward cell zero
    for (genvar i = 0; i < CAPACITY; i++) begin : g_ring
        logic [VALUE_WIDTH-1:0] cell_d;
        if (i == CAPACITY - 1) begin : g_tail
            assign cell_d = feed;
        end else begin : g_body
            assign cell_d = ring_q[i+1];
        end
        ple_cell #(.W(VALUE_WIDTH)) u_cell (
            .aclk (aclk),
            .en   (shift_en),
            .d    (cell_d),
            .q    (ring_q[i])
        );
    end

    // Seam cell closing the ring between cell zero and the tail
    ple_cell #(.W(VALUE_WIDTH)) u_seam (
        .aclk (aclk),
        .en   (seam_en),
        .d    (seam_d),
        .q    (seam_q)
    );

    // Admission check against the current length
    assign pos_in    = PW'(s_data.position);
    assign count_ext = PW'(count_reg);
    assign full      = (count_reg == CW'(CAPACITY));

    always_comb begin
        case (op_t'(s_data.req_type))
            OP_APPEND: act_in = !full;
            OP_INSERT: act_in = (pos_in <= count_ext) && !full;
            OP_SET:    act_in = (pos_in < count_ext);
            OP_GET:    act_in = (pos_in < count_ext);
            OP_REMOVE: act_in = (pos_in < count_ext);
            OP_SEARCH: act_in = 1'b1;
            default:   act_in = 1'b0;
        endcase
    end

    // Rewrite the word stream at the seam
    assign step_ext  = PW'(step_reg);
    assign at_pos    = (step_ext == pos_reg);
    assign past_pos  = (step_ext > pos_reg);
    assign last_step = (step_reg == CW'(CAPACITY));

    always_comb begin
        seam_d     = head;
        seam_en    = shift_en;
        feed       = seam_q;
        carry_next = carry_reg;
        found_next = found_reg;
        fpos_next  = fpos_reg;
        rd_next    = rd_reg;
        if (act_reg) begin
            case (op_reg)
                OP_APPEND: begin
                    if (step_reg == count_reg) begin
                        seam_d = val_reg;
                    end
                end
                OP_INSERT: begin
                    if (at_pos) begin
                        seam_d     = val_reg;
                        carry_next = head;
                    end else if (past_pos) begin
                        seam_d     = carry_reg;
                        carry_next = head;
                    end
                end
                OP_SET: begin
                    if (at_pos) begin
                        seam_d = val_reg;
                    end
                end
                OP_GET: begin
                    if (at_pos && shift_en) begin
                        rd_next = VAL_W'(head);
                    end
                end
                OP_REMOVE: begin
                    // bypass the seam cell so later words close up by one
                    if (past_pos) begin
                        feed    = head;
                        seam_en = 1'b0;
                    end
                end
                OP_SEARCH: begin
                    if (shift_en && !found_reg && (step_reg < count_reg)
                        && (head == val_reg)) begin
                        found_next = 1'b1;
                        fpos_next  = FPOS_W'(step_reg);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Length and status after the request
    always_comb begin
        count_new = count_reg;
        if (act_reg && ((op_reg == OP_APPEND) || (op_reg == OP_INSERT))) begin
            count_new = count_reg + CW'(1);
        end else if (act_reg && (op_reg == OP_REMOVE)) begin
            count_new = count_reg - CW'(1);
        end
    end

    assign ok_out = (op_reg == OP_SEARCH) ? found_reg : act_reg;

    // Sequence the rotation and hold the response register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            count_reg   <= '0;
            act_reg     <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_SWEEP;
                        step_reg  <= '0;
                        act_reg   <= act_in;
                        found_reg <= 1'b0;
                    end
                end
                ST_SWEEP: begin
                    found_reg <= found_next;
                    if (last_step) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        step_reg <= step_reg + CW'(1);
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg               <= 1'b1;
                        m_data_reg.ok             <= ok_out;
                        m_data_reg.read_value     <= rd_reg;
                        m_data_reg.found_position <= fpos_reg;
                        m_data_reg.length         <= LEN_W'(count_new);
                        count_reg                 <= count_new;
                        state_reg                 <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Capture the request and advance the seam datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= op_t'(s_data.req_type);
            pos_reg  <= pos_in;
            val_reg  <= VALUE_WIDTH'(s_data.value);
            rd_reg   <= '0;
            fpos_reg <= '0;
        end else begin
            rd_reg   <= rd_next;
            fpos_reg <= fpos_next;
        end
        if (shift_en) begin
            carry_reg <= carry_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/ple_cell.sv @@
// ----------------------------------------------------------------------------
// ple_cell
// One storage cell of the element ring: loads its neighbor's word when enabled.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; #(
    parameter int W = DEF_VALUE_WIDTH
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] data_reg;

    // Take the neighbor's word on each shift, hold otherwise
    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

@@ rtl/ple_checker.sv @@
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_list_engine_unit_macros.svh"

module ple_checker import ple_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input ple_rsp_t m_data
);

    // Hold a stalled response beat
    `PLE_ASSERT_NEXT(a_rsp_hold, m_valid && !m_ready, m_valid && $stable(m_data), "response beat changed while stalled")

    // Drop ready once a request beat is taken
    `PLE_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready stayed high after request beat")

    // Refused or missed requests report zero read value and position
    `PLE_ASSERT_NOW(a_refused_clean, m_valid && !m_data.ok, (m_data.read_value == '0) && (m_data.found_position == '0), "nonzero payload on refused response")

    // Length never exceeds the capacity
    `PLE_ASSERT_NOW(a_len_bound, m_valid, int'(m_data.length) <= CAPACITY, "length beyond capacity")

endmodule

bind positional_list_engine_unit ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);

@@ dv/positional_list_engine_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit_test
// Self-checking bench for the positional list engine. Directed beats walk the
// refusal paths (empty list, position past the end, unknown request) and
// every request kind. Random beats then fill the list to capacity, knock on
// the full store and drain it again. A queue-based mirror of the list predicts
// each response beat, and responses are compared in order, field by field.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_test;
    import ple_pkg::*;

    localparam int CAP            = DEF_CAPACITY;
    localparam int DIRECTED_ITEMS = 23;
    localparam int RANDOM_ITEMS   = 527;
    localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + RANDOM_ITEMS;
    localparam int STALL_LIMIT    = 4000;
    localparam logic [VAL_W-1:0] VALUE_MASK = {VAL_W{1'b1}} >> (VAL_W - DEF_VALUE_WIDTH);

    // Request codes the block does not define
    localparam logic [REQ_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] OP_RSVD7 = 3'd7;

    // Mirror of the stored list and the responses it predicts
    class list_mirror;
        logic [VAL_W-1:0] elems[$];
        ple_rsp_t         pending_rsp[$];
        int               errors;
        int               n_requests;
        int               n_refused;
        int               full_hits;
        int               peak_len;

        function int count();
            return elems.size();
        endfunction

        function int pending();
            return pending_rsp.size();
        endfunction

        // Apply one accepted request and queue the response it must give
        function void note_request(ple_req_t r);
            ple_rsp_t         e;
            int               pos;
            int               n;
            logic [VAL_W-1:0] v;
            e   = '0;
            pos = int'(r.position);
            n   = elems.size();
            v   = r.value & VALUE_MASK;
            case (r.req_type)
                OP_APPEND: begin
                    if (n < CAP) begin
                        elems.push_back(v);
                        e.ok = 1'b1;
                    end
                end
                OP_INSERT: begin
                    if (pos <= n && n < CAP) begin
                        elems.insert(pos, v);
                        e.ok = 1'b1;
                    end
                end
                OP_SET: begin
                    if (pos < n) begin
                        elems[pos] = v;
                        e.ok = 1'b1;
                    end
                end
                OP_GET: begin
                    if (pos < n) begin
                        e.read_value = elems[pos];
                        e.ok = 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (pos < n) begin
                        elems.delete(pos);
                        e.ok = 1'b1;
                    end
                end
                OP_SEARCH: begin
                    for (int i = 0; i < n; i++) begin
                        if (!e.ok && elems[i] == v) begin
                            e.found_position = FPOS_W'(i);
                            e.ok = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            e.length = LEN_W'(elems.size());
            if ((r.req_type == OP_APPEND || r.req_type == OP_INSERT) && n == CAP)
                full_hits++;
            if (!e.ok)
                n_refused++;
            if (elems.size() > peak_len)
                peak_len = elems.size();
            n_requests++;
            pending_rsp.push_back(e);
        endfunction

        function void field_check(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare one response beat with the oldest prediction
        function void check_response(ple_rsp_t a);
            ple_rsp_t e;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response beat, expected none, got 0x%0h",
                         $time, a);
                errors++;
                return;
            end
            e = pending_rsp.pop_front();
            field_check("ok", 64'(e.ok), 64'(a.ok));
            field_check("read_value", 64'(e.read_value), 64'(a.read_value));
            field_check("found_position", 64'(e.found_position), 64'(a.found_position));
            field_check("length", 64'(e.length), 64'(a.length));
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    ple_req_t s_data;
    logic     m_valid;
    logic     m_ready;
    ple_rsp_t m_data;

    list_mirror sb;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         stall_cycles;

    positional_list_engine_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Toggle the response ready at random, per the current idle rate
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Track accepted beats on both channels and guard against a hang
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_cycles = 0;
        end else begin
            if (s_valid && s_ready)
                sb.note_request(s_data);
            if (m_valid && m_ready)
                sb.check_response(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                $display("[positional_list_engine_unit] ERROR");
                $finish;
            end
        end
    end

    // Present one request beat and hold it until accepted
    task automatic send_request(input ple_req_t r);
        int gap;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, CAP + 4);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  = r;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_fields(input logic [REQ_W-1:0] kind, input int pos,
                               input logic [VAL_W-1:0] v);
        ple_req_t r;
        r.req_type = kind;
        r.position = POS_W'(pos);
        r.value    = v;
        send_request(r);
    endtask

    // Favor growth or shrinkage of the list
    function automatic logic [REQ_W-1:0] pick_op(bit grow);
        int roll;
        roll = $urandom_range(0, 99);
        if (grow) begin
            if (roll < 45) return OP_APPEND;
            if (roll < 80) return OP_INSERT;
            if (roll < 85) return OP_SET;
            if (roll < 90) return OP_GET;
            if (roll < 95) return OP_SEARCH;
            return OP_REMOVE;
        end
        if (roll < 55) return OP_REMOVE;
        if (roll < 67) return OP_GET;
        if (roll < 79) return OP_SET;
        if (roll < 91) return OP_SEARCH;
        if (roll < 96) return OP_APPEND;
        return OP_INSERT;
    endfunction

    // Build a mostly well-formed request against the current list
    function automatic ple_req_t make_request(bit grow);
        ple_req_t r;
        int       n;
        n = sb.count();
        r.value = $urandom;
        if ($urandom_range(0, 9) == 0)
            r.value = $urandom_range(0, 1) ? '1 : '0;
        // Noise: any code, any position
        if ($urandom_range(0, 99) < 6) begin
            r.req_type = REQ_W'($urandom_range(0, 7));
            r.position = POS_W'($urandom_range(0, 511));
            return r;
        end
        r.req_type = pick_op(grow);
        if (r.req_type == OP_INSERT)
            r.position = POS_W'($urandom_range(0, n));
        else
            r.position = (n > 0) ? POS_W'($urandom_range(0, n - 1)) : '0;
        // Occasionally aim past the end
        if ($urandom_range(0, 19) == 0)
            r.position = POS_W'($urandom_range(n, 511));
        // Hit a stored value in half the searches
        if (r.req_type == OP_SEARCH && n > 0 && $urandom_range(0, 1))
            r.value = sb.elems[$urandom_range(0, n - 1)];
        return r;
    endfunction

    initial begin
        bit grow;
        int full_extra;
        int item;

        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        send_idle_pct = 24;
        recv_idle_pct = 71;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // Refusals on the empty list
        send_fields(OP_GET,    0, 32'h0);
        send_fields(OP_REMOVE, 0, 32'h0);
        send_fields(OP_SEARCH, 0, 32'h0);
        send_fields(OP_SET,    0, 32'h1);
        send_fields(OP_INSERT, 1, 32'h2);
        // Build a short list, insert at the head and at the tail
        send_fields(OP_APPEND, 0, 32'h0000_0000);
        send_fields(OP_APPEND, 0, 32'hFFFF_FFFF);
        send_fields(OP_INSERT, 0, 32'h1234_5678);
        send_fields(OP_INSERT, 3, 32'hA5A5_A5A5);
        send_fields(OP_INSERT, 5, 32'h3C3C_3C3C);
        send_fields(OP_GET,    1, 32'h0);
        send_fields(OP_SET,    3, 32'h5A5A_5A5A);
        // Positions with the top bit set
        send_fields(OP_GET,    256, 32'h0);
        send_fields(OP_REMOVE, 511, 32'h0);
        // Search hit and miss
        send_fields(OP_SEARCH, 0, 32'hFFFF_FFFF);
        send_fields(OP_SEARCH, 0, 32'hDEAD_BEEF);
        // Unknown request codes
        send_fields(OP_RSVD6, 511, 32'hFFFF_FFFF);
        send_fields(OP_RSVD7, 0, 32'h0);
        // Close up from the middle and from the tail
        send_fields(OP_REMOVE, 1, 32'h0);
        send_fields(OP_GET,    2, 32'h0);
        send_fields(OP_REMOVE, 2, 32'h0);
        // Duplicate value: search reports the first match
        send_fields(OP_APPEND, 0, 32'h1234_5678);
        send_fields(OP_SEARCH, 7, 32'h1234_5678);

        // Fill to capacity, knock on the full store, then drain
        grow       = 1'b1;
        full_extra = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            item = DIRECTED_ITEMS + i;
            if (item == TOTAL_ITEMS / 3) begin
                send_idle_pct = 71;
                recv_idle_pct = 24;
            end else if (item == 2 * TOTAL_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (grow && sb.count() == CAP)
                full_extra++;
            if (full_extra > 8)
                grow = 1'b0;
            if (!grow && sb.count() < 4) begin
                grow       = 1'b1;
                full_extra = 0;
            end
            send_request(make_request(grow));
        end
        s_valid = 1'b0;

        // Drain outstanding responses, then watch for strays
        while (sb.pending() != 0) @(posedge aclk);
        repeat (CAP + 8) @(posedge aclk);

        $display("run covered %0d requests, %0d answered with ok low, peak length %0d",
                 sb.n_requests, sb.n_refused, sb.peak_len);
        $display("append or insert refused on a full list %0d times, %0d mismatches",
                 sb.full_hits, sb.errors);
        if (sb.errors == 0) begin
            $display("[positional_list_engine_unit] OK");
        end else begin
            $display("[positional_list_engine_unit] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine_unit.sv
rtl/ple_checker.sv
dv/positional_list_engine_unit_test.sv
